[hw/rtl/brb_pkg.sv]
`default_nettype none

package brb_pkg;

  localparam int SLOTS_DEFAULT = 1024;
  localparam int CAP_W         = 10;
  localparam int BYTE_W        = 8;
  localparam int CAP_RESET     = 1023;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] push_byte;
    logic [CAP_W-1:0]  offset;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [CAP_W-1:0]  used_count;
    logic              is_empty;
    logic              is_full;
    logic              overwrote;
    logic              in_range;
  } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/brb_ram.sv]
`default_nettype none

module brb_ram #(
  parameter int DEPTH = brb_pkg::SLOTS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [brb_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [brb_pkg::BYTE_W-1:0] rd_data
);
  import brb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/byte_ring_buffer_overwrite.sv]
// Byte ring buffer that overwrites its oldest entry when full.
// Request channel (req_valid, req_stall, req) carries one operation per
// transfer: push, pop, peek at an offset from the oldest byte, or clear.
// Response channel (rsp_valid, rsp_stall, rsp) returns exactly one result
// per request, in order, with the byte read and the fill state afterwards.
// The response is registered: a request taken at one edge shows its response
// after that edge. Throughput is one request per cycle while the response
// side is not stalling; pointer update and the memory read port run once
// per request.
// When rsp_valid is high and rsp_stall is high, the response and the read
// data register hold and req_stall goes high until the response is taken.
// cfg_wr_en/cfg_wr_data write the capacity (clamped to 1..SLOTS-1) and
// empty the buffer; write it only while no response is pending.
// Reset (rst, synchronous) empties the buffer, sets the capacity to 1023
// (or SLOTS-1 if smaller) and drops any pending response. The byte store
// is not cleared; only written entries are ever returned.
`default_nettype none

module byte_ring_buffer_overwrite #(
  parameter int SLOTS = brb_pkg::SLOTS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire brb_pkg::req_t             req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output brb_pkg::rsp_t                  rsp,
  input  wire logic                      cfg_wr_en,
  input  wire logic [brb_pkg::CAP_W-1:0] cfg_wr_data
);
  import brb_pkg::*;

  localparam int PW     = $clog2(SLOTS);
  localparam int XW     = ((PW > CAP_W) ? PW : CAP_W) + 2;
  localparam int MaxCap = SLOTS - 1;
  localparam int CapRst = (CAP_RESET > MaxCap) ? MaxCap : CAP_RESET;

  logic [PW-1:0] rd_pos, wr_pos, cap_eff;
  logic [PW-1:0] rd_pos_next, wr_pos_next;
  logic [PW-1:0] rd_adv, wr_adv, ram_rd_addr;
  logic [XW-1:0] cfg_x, cap_lim;
  logic [XW-1:0] rd_x, wr_x, cap_x, size_x, used, used_next;
  logic [XW-1:0] peek_sum, peek_idx;
  logic          accept, ram_we, ovw, inr;

  logic [BYTE_W-1:0] rd_data;
  logic [CAP_W-1:0]  rsp_used;
  logic              rsp_empty, rsp_full, rsp_ovw, rsp_inr;

  assign accept    = req_valid && !req_stall;
  assign req_stall = rsp_valid && rsp_stall;

  // capacity clamp
  always_comb begin
    cfg_x = XW'(cfg_wr_data);
    if (cfg_x == '0) begin
      cap_lim = XW'(1);
    end else if (cfg_x > XW'(MaxCap)) begin
      cap_lim = XW'(MaxCap);
    end else begin
      cap_lim = cfg_x;
    end
  end

  always_comb begin
    rd_x   = XW'(rd_pos);
    wr_x   = XW'(wr_pos);
    cap_x  = XW'(cap_eff);
    size_x = cap_x + XW'(1);

    if (wr_pos >= rd_pos) begin
      used = wr_x - rd_x;
    end else begin
      used = size_x + wr_x - rd_x;
    end

    rd_adv = (rd_pos == cap_eff) ? '0 : rd_pos + PW'(1);
    wr_adv = (wr_pos == cap_eff) ? '0 : wr_pos + PW'(1);

    peek_sum = rd_x + XW'(req.offset) + XW'(1);
    peek_idx = (peek_sum >= size_x) ? peek_sum - size_x : peek_sum;

    rd_pos_next = rd_pos;
    wr_pos_next = wr_pos;
    used_next   = used;
    ram_rd_addr = rd_adv;
    ram_we      = 1'b0;
    ovw         = 1'b0;
    inr         = 1'b0;

    case (req.kind)
      KIND_PUSH: begin
        wr_pos_next = wr_adv;
        ram_we      = 1'b1;
        if (used == cap_x) begin
          rd_pos_next = rd_adv;
          ovw         = 1'b1;
        end else begin
          used_next = used + XW'(1);
        end
      end
      KIND_POP: begin
        if (used != '0) begin
          rd_pos_next = rd_adv;
          used_next   = used - XW'(1);
          inr         = 1'b1;
        end
      end
      KIND_PEEK: begin
        ram_rd_addr = peek_idx[PW-1:0];
        inr         = (XW'(req.offset) < used);
      end
      KIND_CLEAR: begin
        rd_pos_next = wr_pos;
        used_next   = '0;
      end
      default: begin
        rd_pos_next = rd_pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pos    <= '0;
      wr_pos    <= '0;
      cap_eff   <= PW'(CapRst);
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rd_pos  <= '0;
        wr_pos  <= '0;
        cap_eff <= cap_lim[PW-1:0];
      end else if (accept) begin
        rd_pos <= rd_pos_next;
        wr_pos <= wr_pos_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_used  <= used_next[CAP_W-1:0];
      rsp_empty <= (used_next == '0);
      rsp_full  <= (used_next == cap_x);
      rsp_ovw   <= ovw;
      rsp_inr   <= inr;
    end
  end

  brb_ram #(
    .DEPTH(SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept && ram_we),
    .wr_addr (wr_adv),
    .wr_data (req.push_byte),
    .rd_en   (accept),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    rsp.read_byte  = rsp_inr ? rd_data : '0;
    rsp.used_count = rsp_used;
    rsp.is_empty   = rsp_empty;
    rsp.is_full    = rsp_full;
    rsp.overwrote  = rsp_ovw;
    rsp.in_range   = rsp_inr;
  end

endmodule

`default_nettype wire

[tb/sv/brb_checker.sv]
`default_nettype none

module brb_checker
  import brb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  input  wire logic             req_stall,
  input  wire req_t             req,
  input  wire logic             rsp_valid,
  input  wire logic             rsp_stall,
  input  wire rsp_t             rsp,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  output int                    errors,
  output int                    pending,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [BYTE_W-1:0] ring_mem [0:SLOTS_DEFAULT-1];
  int                oldest_gap;
  int                newest_pos;
  logic [CAP_W-1:0]  cap_reg;
  rsp_t              rsp_due [$];
  int                err_cnt;
  int                chk_cnt;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
    err_cnt = 0;
    chk_cnt = 0;
    oldest_gap = 0;
    newest_pos = 0;
    cap_reg = CAP_W'(CAP_RESET);
    for (int i = 0; i < SLOTS_DEFAULT; i++) ring_mem[i] = '0;
  end

  function automatic int fill_level(int ring_len);
    if (newest_pos >= oldest_gap) return newest_pos - oldest_gap;
    return ring_len - oldest_gap + newest_pos;
  endfunction

  // applies one operation to the local ring and returns its result
  function automatic rsp_t next_response(req_t r);
    rsp_t res;
    int   cap_eff;
    int   ring_len;
    int   used;
    cap_eff = (cap_reg == 0) ? 1 : int'(cap_reg);
    if (cap_eff > SLOTS_DEFAULT - 1) cap_eff = SLOTS_DEFAULT - 1;
    ring_len = cap_eff + 1;
    if (oldest_gap >= ring_len) oldest_gap = 0;
    if (newest_pos >= ring_len) newest_pos = 0;
    res = '0;
    used = fill_level(ring_len);
    case (r.kind)
      KIND_PUSH: begin
        if (used == cap_eff) begin
          oldest_gap = (oldest_gap + 1) % ring_len;
          res.overwrote = 1'b1;
        end
        newest_pos = (newest_pos + 1) % ring_len;
        ring_mem[newest_pos] = r.push_byte;
      end
      KIND_POP: begin
        if (used != 0) begin
          oldest_gap = (oldest_gap + 1) % ring_len;
          res.read_byte = ring_mem[oldest_gap];
          res.in_range = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (int'(r.offset) < used) begin
          res.read_byte = ring_mem[(oldest_gap + int'(r.offset) + 1) % ring_len];
          res.in_range = 1'b1;
        end
      end
      default: begin
        oldest_gap = newest_pos;
      end
    endcase
    used = fill_level(ring_len);
    res.used_count = used[CAP_W-1:0];
    res.is_empty = (used == 0);
    res.is_full = (used == cap_eff);
    return res;
  endfunction

  function automatic void check_field(string fname, int want, int got);
    if (want != got) begin
      err_cnt++;
      $display("%0t brb_checker: %s expected %0h got %0h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_due.delete();
      oldest_gap = 0;
      newest_pos = 0;
      cap_reg = CAP_W'(CAP_RESET);
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          err_cnt++;
          $display("%0t brb_checker: response with none expected, got %h", $time, rsp);
        end else begin
          want = rsp_due.pop_front();
          chk_cnt++;
          check_field("read_byte", int'(want.read_byte), int'(rsp.read_byte));
          check_field("used_count", int'(want.used_count), int'(rsp.used_count));
          check_field("is_empty", int'(want.is_empty), int'(rsp.is_empty));
          check_field("is_full", int'(want.is_full), int'(rsp.is_full));
          check_field("overwrote", int'(want.overwrote), int'(rsp.overwrote));
          check_field("in_range", int'(want.in_range), int'(rsp.in_range));
        end
      end
      if (cfg_wr_en) begin
        cap_reg = cfg_wr_data;
        oldest_gap = 0;
        newest_pos = 0;
      end
      if (req_valid && !req_stall) rsp_due.push_back(next_response(req));
    end
    errors  <= err_cnt;
    pending <= rsp_due.size();
    checked <= chk_cnt;
  end

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none

module tb_top;
  import brb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  int errors;
  int pending;
  int checked;
  int cycles;
  int n_sent;
  int n_cfg;
  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_cycles;
  int cur_cap;

  byte_ring_buffer_overwrite u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  brb_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cycles = 0;
    n_sent = 0;
    n_cfg = 0;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_cycles = 0;
    cur_cap = CAP_RESET;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // response side: random stall plus a long hold-off when a phase requests one
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  function automatic req_t mk(kind_t k, logic [BYTE_W-1:0] b, logic [CAP_W-1:0] off);
    req_t r;
    r.kind = k;
    r.push_byte = b;
    r.offset = off;
    return r;
  endfunction

  function automatic req_t rand_req(int push_pct, int pop_pct);
    req_t r;
    int   pick;
    int   top_off;
    pick = $urandom_range(0, 99);
    top_off = (cur_cap == 0) ? 2 : cur_cap + 1;
    if (top_off > 1023) top_off = 1023;
    r.push_byte = BYTE_W'($urandom_range(0, 255));
    r.offset = ($urandom_range(0, 3) == 0) ? CAP_W'($urandom_range(0, 1023))
                                           : CAP_W'($urandom_range(0, top_off));
    if (pick < push_pct) r.kind = KIND_PUSH;
    else if (pick < push_pct + pop_pct) r.kind = KIND_POP;
    else if (pick < 97) r.kind = KIND_PEEK;
    else r.kind = KIND_CLEAR;
    return r;
  endfunction

  task automatic send(input req_t r);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    cur_cap = int'(v);
    n_cfg++;
  endtask

  initial begin
    int phase_caps [7];
    int push_pct;
    int pop_pct;
    phase_caps = '{5, 1, 0, 40, 2, 300, 7};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queue, edges of the fields, overwrite at tiny capacity
    send(mk(KIND_POP, 8'h00, 10'd0));
    send(mk(KIND_PEEK, 8'h00, 10'd0));
    send(mk(KIND_PEEK, 8'hFF, 10'd1022));
    send(mk(KIND_CLEAR, 8'h00, 10'd0));
    send(mk(KIND_PUSH, 8'h00, 10'd0));
    send(mk(KIND_PUSH, 8'hFF, 10'h3FF));
    send(mk(KIND_PEEK, 8'h00, 10'd0));
    send(mk(KIND_PEEK, 8'h00, 10'd1));
    send(mk(KIND_PEEK, 8'h00, 10'd2));
    send(mk(KIND_PEEK, 8'h00, 10'h3FF));
    send(mk(KIND_POP, 8'h00, 10'd0));
    send(mk(KIND_POP, 8'h00, 10'd0));
    send(mk(KIND_POP, 8'h00, 10'd0));
    write_capacity(10'd0);
    send(mk(KIND_PUSH, 8'hA5, 10'd0));
    send(mk(KIND_PUSH, 8'h5A, 10'd0));
    send(mk(KIND_PEEK, 8'h00, 10'd0));
    send(mk(KIND_POP, 8'h00, 10'd0));
    send(mk(KIND_PUSH, 8'h3C, 10'd0));
    send(mk(KIND_CLEAR, 8'h00, 10'd0));
    send(mk(KIND_POP, 8'h00, 10'd0));
    write_capacity(10'd1);
    send(mk(KIND_PUSH, 8'h81, 10'd0));
    send(mk(KIND_PUSH, 8'h7E, 10'd0));
    send(mk(KIND_POP, 8'h00, 10'd0));

    // random phases over small capacities
    for (int p = 0; p < 7; p++) begin
      write_capacity(CAP_W'(phase_caps[p]));
      if (p < 3) begin
        snd_idle_pct = 8;
        rcv_idle_pct = 64;
      end else if (p < 6) begin
        snd_idle_pct = 64;
        rcv_idle_pct = 8;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (p == 3) hold_cycles = 300;
      push_pct = $urandom_range(35, 65);
      pop_pct = (97 - push_pct) * 2 / 3;
      for (int i = 0; i < 150; i++) send(rand_req(push_pct, pop_pct));
    end

    // fill the largest ring until it wraps and overwrites, then read it back
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_capacity(10'd1023);
    for (int i = 0; i < 1030; i++) send(mk(KIND_PUSH, 8'($urandom_range(0, 255)), 10'd0));
    send(mk(KIND_PEEK, 8'h00, 10'd1022));
    send(mk(KIND_PEEK, 8'h00, 10'h3FF));
    for (int i = 0; i < 20; i++) send(rand_req(0, 0));
    for (int i = 0; i < 30; i++) send(mk(KIND_POP, 8'h00, 10'd0));
    send(mk(KIND_CLEAR, 8'h00, 10'd0));
    send(mk(KIND_POP, 8'h00, 10'd0));

    drain();
    repeat (10) @(posedge clk);
    $display("tb_top: %0d requests sent, %0d responses checked, %0d capacity writes",
             n_sent, checked, n_cfg);
    $display("tb_top: capacities 0, 1, 1023 and several small rings, with stalls both sides");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
